>>> hw/rtl/pidf_pkg.sv
package pidf_pkg;

  localparam int DATA_WIDTH      = 16;
  localparam int GAIN_WIDTH      = 24;
  localparam int ALPHA_BITS      = 16;
  localparam int ALPHA_WIDTH     = ALPHA_BITS + 1;
  localparam int CFG_WIDTH       = (GAIN_WIDTH > DATA_WIDTH) ? GAIN_WIDTH : DATA_WIDTH;
  localparam int REG_INDEX_WIDTH = 3;

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_LIMIT_LOW   = 3'd3,
    REG_LIMIT_HIGH  = 3'd4,
    REG_DEAD_BAND   = 3'd5,
    REG_DERIV_ALPHA = 3'd6,
    REG_DRIVE_ALPHA = 3'd7
  } pidf_reg_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] target;
    logic signed [DATA_WIDTH-1:0] measured;
  } pidf_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         clamped;
  } pidf_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_MUL_P,
    ST_MUL_DF,
    ST_DF_DONE,
    ST_MUL_D,
    ST_SUM,
    ST_MUL_OF,
    ST_OF_DONE,
    ST_OUT
  } pidf_state_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MS_GAIN_I,
    MS_GAIN_P,
    MS_DERIV_FILT,
    MS_GAIN_D,
    MS_DRIVE_FILT
  } pidf_mul_sel_t;

  typedef struct packed {
    logic          load_sample;
    logic          mul_en;
    pidf_mul_sel_t mul_sel;
    logic          int_update;
    logic          sum_load;
    logic          sum_add_int;
    logic          deriv_update;
    logic          drive_sat;
    logic          drive_update;
    logic          out_load;
  } pidf_cmd_t;

  typedef struct packed {
    logic out_free;
  } pidf_status_t;

endpackage

>>> hw/rtl/pidf_ctrl.sv
module pidf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pidf_pkg::pidf_status_t status,
  output pidf_pkg::pidf_cmd_t    cmd
);
  import pidf_pkg::*;

  pidf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = rst || (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_MUL_I;
      ST_MUL_I:   state_next = ST_MUL_P;
      ST_MUL_P:   state_next = ST_MUL_DF;
      ST_MUL_DF:  state_next = ST_DF_DONE;
      ST_DF_DONE: state_next = ST_MUL_D;
      ST_MUL_D:   state_next = ST_SUM;
      ST_SUM:     state_next = ST_MUL_OF;
      ST_MUL_OF:  state_next = ST_OF_DONE;
      ST_OF_DONE: state_next = ST_OUT;
      ST_OUT:     if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MS_GAIN_I;
    unique case (state)
      ST_IDLE:    cmd.load_sample = in_valid;
      ST_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_GAIN_I;
      end
      ST_MUL_P: begin
        cmd.int_update = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = MS_GAIN_P;
      end
      ST_MUL_DF: begin
        cmd.sum_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_DERIV_FILT;
      end
      ST_DF_DONE: begin
        cmd.deriv_update = 1'b1;
        cmd.sum_add_int  = 1'b1;
      end
      ST_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_GAIN_D;
      end
      ST_SUM:     cmd.drive_sat = 1'b1;
      ST_MUL_OF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_DRIVE_FILT;
      end
      ST_OF_DONE: cmd.drive_update = 1'b1;
      ST_OUT:     cmd.out_load = status.out_free;
      default:    cmd = '0;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load_sample |=> state == ST_MUL_I)
    else $error("accepted sample did not start the sequence");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free && state == ST_OUT)
    else $error("result loaded over an untaken result");

  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !status.out_free) |=> state == ST_OUT)
    else $error("left output state while output register full");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !cmd.load_sample)
    else $error("sample loaded while sequence busy");

endmodule

>>> hw/rtl/pidf_datapath.sv
module pidf_datapath #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  pidf_pkg::pidf_in_t                        in_data,
  input  logic                                      cfg_write,
  input  logic [pidf_pkg::REG_INDEX_WIDTH-1:0]      cfg_index,
  input  logic [pidf_pkg::CFG_WIDTH-1:0]            cfg_data,
  input  pidf_pkg::pidf_cmd_t                       cmd,
  output pidf_pkg::pidf_status_t                    status,
  input  logic                                      out_stall,
  output logic                                      out_valid,
  output pidf_pkg::pidf_out_t                       out_data
);
  import pidf_pkg::*;

  localparam int F        = GAIN_FRAC_BITS;
  localparam int ACC_WANT = DATA_WIDTH + F + 4;
  localparam int ACC_BITS = (ACC_WANT < 44) ? ACC_WANT : 44;
  localparam int EW       = DATA_WIDTH + 1;     // error / difference
  localparam int IW       = DATA_WIDTH + F;     // integral
  localparam int MAW      = ACC_BITS + 1;       // multiplier operand a
  localparam int MBW      = GAIN_WIDTH;         // multiplier operand b
  localparam int PW       = MAW + MBW;          // product
  localparam int SW       = PW + 2;             // sums and blends
  localparam int RW       = ACC_BITS + 1;       // rounding add
  localparam int YW       = RW - F;             // rounded drive

  localparam logic signed [SW-1:0] ACC_MAX =
    {{(SW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_MIN =
    {{(SW-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [SW-1:0] BLEND_HALF = SW'(1) <<< (ALPHA_BITS - 1);
  localparam logic signed [RW-1:0] ROUND_HALF = RW'(1) <<< (F - 1);

  function automatic logic signed [EW-1:0] dead_zone(
    input logic signed [EW-1:0]   v,
    input logic [DATA_WIDTH-1:0]  band
  );
    logic [EW-1:0] mag;
    mag = v[EW-1] ? EW'(-v) : EW'(v);
    return (mag < {1'b0, band}) ? '0 : v;
  endfunction

  // configuration
  logic signed [GAIN_WIDTH-1:0] gain_p, gain_i, gain_d;
  logic signed [DATA_WIDTH-1:0] limit_low, limit_high;
  logic [DATA_WIDTH-1:0]        dead_band;
  logic [ALPHA_WIDTH-1:0]       deriv_alpha, drive_alpha;

  // loop state
  logic signed [DATA_WIDTH-1:0] prior_measured;
  logic signed [IW-1:0]         integral_acc;
  logic signed [EW-1:0]         filtered_diff;
  logic signed [ACC_BITS-1:0]   filtered_drive;

  // working registers
  logic signed [EW-1:0]         err_q, diff_q;
  logic signed [PW-1:0]         prod;
  logic signed [SW-1:0]         sum;
  logic signed [ACC_BITS-1:0]   drive_q;

  pidf_reg_t cfg_reg;
  logic      wr_low, wr_high;

  assign cfg_reg = pidf_reg_t'(cfg_index);
  assign wr_low  = cfg_write && (cfg_reg == REG_LIMIT_LOW);
  assign wr_high = cfg_write && (cfg_reg == REG_LIMIT_HIGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= '0;
      gain_i      <= '0;
      gain_d      <= '0;
      limit_low   <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
      limit_high  <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
      dead_band   <= '0;
      deriv_alpha <= {1'b1, {ALPHA_BITS{1'b0}}};
      drive_alpha <= {1'b1, {ALPHA_BITS{1'b0}}};
    end else if (cfg_write) begin
      unique case (cfg_reg)
        REG_GAIN_P:      gain_p      <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_I:      gain_i      <= cfg_data[GAIN_WIDTH-1:0];
        REG_GAIN_D:      gain_d      <= cfg_data[GAIN_WIDTH-1:0];
        REG_LIMIT_LOW:   limit_low   <= cfg_data[DATA_WIDTH-1:0];
        REG_LIMIT_HIGH:  limit_high  <= cfg_data[DATA_WIDTH-1:0];
        REG_DEAD_BAND:   dead_band   <= cfg_data[DATA_WIDTH-1:0];
        REG_DERIV_ALPHA: deriv_alpha <= cfg_data[ALPHA_WIDTH-1:0];
        REG_DRIVE_ALPHA: drive_alpha <= cfg_data[ALPHA_WIDTH-1:0];
        default:         ;
      endcase
    end
  end

  // shared multiplier operands
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;

  always_comb begin
    unique case (cmd.mul_sel)
      MS_GAIN_I: begin
        mul_a = MAW'(err_q);
        mul_b = gain_i;
      end
      MS_GAIN_P: begin
        mul_a = MAW'(err_q);
        mul_b = gain_p;
      end
      MS_DERIV_FILT: begin
        mul_a = MAW'(diff_q) - MAW'(filtered_diff);
        mul_b = $signed({{(MBW-ALPHA_BITS){1'b0}}, deriv_alpha[ALPHA_BITS-1:0]});
      end
      MS_GAIN_D: begin
        mul_a = MAW'(diff_q);
        mul_b = gain_d;
      end
      MS_DRIVE_FILT: begin
        mul_a = MAW'(drive_q) - MAW'(filtered_drive);
        mul_b = $signed({{(MBW-ALPHA_BITS){1'b0}}, drive_alpha[ALPHA_BITS-1:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // integral clamp, shared by the sample update and limit writes; when the
  // limits are crossed, values above the upper bound take it, others the lower
  logic signed [DATA_WIDTH-1:0] lo_sel, hi_sel;
  logic signed [SW-1:0]         int_wide, int_lo, int_hi, int_clamped;

  always_comb begin
    lo_sel   = wr_low  ? $signed(cfg_data[DATA_WIDTH-1:0]) : limit_low;
    hi_sel   = wr_high ? $signed(cfg_data[DATA_WIDTH-1:0]) : limit_high;
    int_lo   = SW'(lo_sel) <<< F;
    int_hi   = SW'(hi_sel) <<< F;
    int_wide = cmd.int_update ? (SW'(integral_acc) + SW'(prod)) : SW'(integral_acc);
    if (int_wide > int_hi) begin
      int_clamped = int_hi;
    end else if (int_wide < int_lo) begin
      int_clamped = int_lo;
    end else begin
      int_clamped = int_wide;
    end
  end

  // exponential filters: prev + (now - prev) * a / 2^16, round half up
  logic signed [SW-1:0] deriv_blend, drive_blend, sum_diff;
  assign deriv_blend = ((SW'(filtered_diff) <<< ALPHA_BITS) + SW'(prod) + BLEND_HALF)
                       >>> ALPHA_BITS;
  assign drive_blend = ((SW'(filtered_drive) <<< ALPHA_BITS) + SW'(prod) + BLEND_HALF)
                       >>> ALPHA_BITS;
  assign sum_diff    = sum - SW'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_measured <= '0;
      integral_acc   <= '0;
      filtered_diff  <= '0;
      filtered_drive <= '0;
    end else begin
      if (cmd.load_sample) begin
        prior_measured <= in_data.measured;
      end
      if (cmd.int_update || wr_low || wr_high) begin
        integral_acc <= IW'(int_clamped);
      end
      if (cmd.deriv_update && !deriv_alpha[ALPHA_BITS]) begin
        filtered_diff <= EW'(deriv_blend);
      end
      if (cmd.drive_update && !drive_alpha[ALPHA_BITS]) begin
        filtered_drive <= ACC_BITS'(drive_blend);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      err_q  <= dead_zone(EW'(in_data.target) - EW'(in_data.measured), dead_band);
      diff_q <= dead_zone(EW'(in_data.measured) - EW'(prior_measured), dead_band);
    end else if (cmd.deriv_update && !deriv_alpha[ALPHA_BITS]) begin
      diff_q <= EW'(deriv_blend);
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.sum_load) begin
      sum <= SW'(prod);
    end else if (cmd.sum_add_int) begin
      sum <= sum + SW'(integral_acc);
    end
    if (cmd.drive_sat) begin
      if (sum_diff > ACC_MAX) begin
        drive_q <= ACC_BITS'(ACC_MAX);
      end else if (sum_diff < ACC_MIN) begin
        drive_q <= ACC_BITS'(ACC_MIN);
      end else begin
        drive_q <= ACC_BITS'(sum_diff);
      end
    end else if (cmd.drive_update && !drive_alpha[ALPHA_BITS]) begin
      drive_q <= ACC_BITS'(drive_blend);
    end
  end

  // round to integer and saturate to the limits
  logic signed [RW-1:0] rnd_sum;
  logic signed [YW-1:0] y_round, y_lo, y_hi;
  pidf_out_t            result;

  always_comb begin
    rnd_sum = RW'(drive_q) + ROUND_HALF;
    y_round = YW'(rnd_sum >>> F);
    y_lo    = YW'(limit_low);
    y_hi    = YW'(limit_high);
    if (y_round > y_hi) begin
      result.drive   = limit_high;
      result.clamped = 1'b1;
    end else if (y_round < y_lo) begin
      result.drive   = limit_low;
      result.clamped = 1'b1;
    end else begin
      result.drive   = DATA_WIDTH'(y_round);
      result.clamped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= result;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("output valid not raised after result load");

  a_integral_in_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.int_update) && !$past(rst) && (limit_low <= limit_high)
      |-> (SW'(integral_acc) <= (SW'(limit_high) <<< F))
       && (SW'(integral_acc) >= (SW'(limit_low) <<< F)))
    else $error("integral left the limit window");

  a_clamp_at_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.clamped)
      |-> (out_data.drive == limit_low) || (out_data.drive == limit_high))
    else $error("clamped result not at a bound");

endmodule

>>> hw/rtl/pid_controller_filtered_top.sv
// PID controller with deadband, derivative filter, output filter and
// integral anti-windup.
//
// Input channel (in_valid / in_stall / in_data): one transfer is one sample,
// a setpoint and a measurement. Output channel (out_valid / out_stall /
// out_data): one transfer per sample, the saturated drive and a clamped flag.
// Config port (cfg_write / cfg_index / cfg_data): one register write per
// cycle, no read-back; write only while no sample is in flight. Writing a
// limit also pulls the integral inside the new limits.
//
// Sequencing: one shared multiplier serves the five products of a sample, so
// the sequencer works on one sample at a time and takes the next one only
// when done. The input is stalled while a sample is in work.
// The output register holds a finished result while the receiver stalls;
// the next sample is taken and worked meanwhile, and the sequencer waits in
// its last step only if the output register is still full.
// Reset: sync, active high; gains, deadband and loop state go to zero,
// limits to the full signed range, both filters off.
module pid_controller_filtered_top #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample in
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  pidf_pkg::pidf_in_t                    in_data,
  // result out
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output pidf_pkg::pidf_out_t                   out_data,
  // register writes
  input  logic                                  cfg_write,
  input  logic [pidf_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [pidf_pkg::CFG_WIDTH-1:0]        cfg_data
);
  import pidf_pkg::*;

  pidf_cmd_t    cmd;
  pidf_status_t status;

  // sequencer: a step per cycle unless waiting; at most one multiply a step
  pidf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, loop state, config registers and output register
  pidf_datapath #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
